### rtl/core/hamming_sec_codec_defines.svh
// Assertion macros shared by the Hamming SEC codec RTL.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef HAMMING_SEC_CODEC_DEFINES_SVH
`define HAMMING_SEC_CODEC_DEFINES_SVH

// Property checked at every clock edge while out of reset.
`define HSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define HSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hsc_pkg.sv
// Types, constants and code-layout functions for the Hamming SEC codec.
// No dependencies; used by hsc_datapath and hamming_sec_codec.
`timescale 1ns / 1ps

package hsc_pkg;

  localparam int unsigned WordW = 63;
  localparam int unsigned PosW  = 6;
  localparam int unsigned SynW  = 6;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_CORR  = 2'd1,
    STAT_RANGE = 2'd2
  } hsc_status_e;

  typedef struct packed {
    logic [PosW-1:0]  code_len;
    logic [WordW-1:0] msg_mask;
    logic [WordW-1:0] code_mask;
  } hsc_cfg_t;

  function automatic logic is_pow2(input int unsigned x);
    return (x != 0) && ((x & (x - 1)) == 0);
  endfunction

  // Fewest parity bits r with 2^r >= m + r + 1 (at most seven steps).
  function automatic int unsigned parity_count(input int unsigned m);
    int unsigned r;
    r = 0;
    while ((1 << r) < (m + r + 1)) r++;
    return r;
  endfunction

  // Word bit that holds message bit k.
  function automatic int unsigned data_pos(input int unsigned k);
    int unsigned cnt;
    int unsigned res;
    cnt = 0;
    res = 0;
    for (int unsigned p = 1; p <= WordW; p++) begin
      if (!is_pow2(p)) begin
        if (cnt == k) res = p - 1;
        cnt++;
      end
    end
    return res;
  endfunction

  // Number of message slots that fit in the word.
  function automatic int unsigned data_slots();
    int unsigned cnt;
    cnt = 0;
    for (int unsigned p = 1; p <= WordW; p++) begin
      if (!is_pow2(p)) cnt++;
    end
    return cnt;
  endfunction

  // Positions whose index has bit b set.
  function automatic logic [WordW-1:0] check_mask(input int unsigned b);
    logic [WordW-1:0] msk;
    msk = '0;
    for (int unsigned p = 1; p <= WordW; p++) begin
      msk[p-1] = ((p >> b) & 1) != 0;
    end
    return msk;
  endfunction

  function automatic logic [SynW-1:0] syndrome(input logic [WordW-1:0] code);
    logic [SynW-1:0] s;
    for (int unsigned b = 0; b < SynW; b++) begin
      s[b] = ^(code & check_mask(b));
    end
    return s;
  endfunction

  function automatic logic [WordW-1:0] scatter(input logic [WordW-1:0] msg);
    logic [WordW-1:0] code;
    code = '0;
    for (int unsigned k = 0; k < data_slots(); k++) begin
      code[data_pos(k)] = msg[k];
    end
    return code;
  endfunction

  function automatic logic [WordW-1:0] gather(input logic [WordW-1:0] code);
    logic [WordW-1:0] msg;
    msg = '0;
    for (int unsigned k = 0; k < data_slots(); k++) begin
      msg[k] = code[data_pos(k)];
    end
    return msg;
  endfunction

  // Derived settings for a clamped message length m.
  function automatic hsc_cfg_t make_cfg(input logic [PosW-1:0] m);
    hsc_cfg_t cfg;
    int unsigned n;
    n = int'(m) + parity_count(int'(m));
    cfg.code_len = n[PosW-1:0];
    for (int unsigned i = 0; i < WordW; i++) begin
      cfg.msg_mask[i]  = i < int'(m);
      cfg.code_mask[i] = i < n;
    end
    return cfg;
  endfunction

endpackage

### rtl/core/hsc_datapath.sv
// Single-pass encode / syndrome-correct logic of the Hamming SEC codec.
// Pure combinational; depends on hsc_pkg for the code layout functions.
`timescale 1ns / 1ps

module hsc_datapath (
  input  logic                      mode_i,
  input  logic [hsc_pkg::WordW-1:0] word_i,
  input  hsc_pkg::hsc_cfg_t         cfg_i,
  output logic [hsc_pkg::WordW-1:0] word_o,
  output logic [hsc_pkg::SynW-1:0]  error_position_o,
  output hsc_pkg::hsc_status_e      status_o
);
  import hsc_pkg::*;

  logic [WordW-1:0] enc_data;
  logic [SynW-1:0]  enc_syn;
  logic [WordW-1:0] enc_parity;
  logic [WordW-1:0] dec_code;
  logic [SynW-1:0]  dec_syn;
  logic             in_range;
  logic [WordW-1:0] flip;

  // Encode: data goes to fixed slots, parity bits take the syndrome bits.
  assign enc_data = scatter(word_i & cfg_i.msg_mask);
  assign enc_syn  = syndrome(enc_data);

  always_comb begin
    enc_parity = '0;
    for (int unsigned b = 0; b < SynW; b++) begin
      enc_parity[(1 << b) - 1] = enc_syn[b];
    end
  end

  // Decode: drop bits past the code length, then fix the named position.
  assign dec_code = word_i & cfg_i.code_mask;
  assign dec_syn  = syndrome(dec_code);
  assign in_range = dec_syn <= cfg_i.code_len;

  always_comb begin
    flip = '0;
    if (dec_syn != '0 && in_range) begin
      flip = {{(WordW-1){1'b0}}, 1'b1} << (dec_syn - SynW'(1));
    end
  end

  always_comb begin
    if (mode_i) begin
      word_o           = gather(dec_code ^ flip);
      error_position_o = dec_syn;
      if (dec_syn == '0) begin
        status_o = STAT_OK;
      end else if (in_range) begin
        status_o = STAT_CORR;
      end else begin
        status_o = STAT_RANGE;
      end
    end else begin
      word_o           = enc_data | enc_parity;
      error_position_o = '0;
      status_o         = STAT_OK;
    end
  end

endmodule

### rtl/core/hamming_sec_codec.sv
// Hamming SEC codec: an accepted item goes through the input register and the
// result register, and is taken from the result register when out_stall_i is low.
// Throughput one item per cycle; input register, one combinational pass,
// result register, with stall flowing back through both stages.
// Reset clears both stage valids and sets data_bits to 4 (code length 7).
// Depends on hsc_pkg, hsc_datapath and hamming_sec_codec_defines.svh.
`timescale 1ns / 1ps

`include "hamming_sec_codec_defines.svh"

module hamming_sec_codec #(
  parameter int unsigned MAX_DATA_BITS = 57
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [5:0]                cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      mode_i,
  input  logic [hsc_pkg::WordW-1:0] word_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [hsc_pkg::WordW-1:0] word_out_o,
  output logic [hsc_pkg::SynW-1:0]  error_position_o,
  output logic [1:0]                status_o
);
  import hsc_pkg::*;

  localparam logic [PosW-1:0] MaxM  = PosW'(MAX_DATA_BITS);
  localparam logic [PosW-1:0] ResetM = PosW'(4);
  localparam int unsigned     MaxN  = MAX_DATA_BITS + parity_count(MAX_DATA_BITS);

  hsc_cfg_t         cfg_q, cfg_d;
  logic [PosW-1:0]  m_clamp;

  logic             s1_valid_q;
  logic             s1_mode_q;
  logic [WordW-1:0] s1_word_q;
  logic             s1_adv;
  logic             s2_adv;

  logic             out_valid_q;
  logic [WordW-1:0] out_word_q,  out_word_d;
  logic [SynW-1:0]  out_pos_q,   out_pos_d;
  hsc_status_e      out_stat_q,  out_stat_d;

  // Clamp the written length and precompute masks once per write.
  always_comb begin
    m_clamp = cfg_wdata_i;
    if (m_clamp == '0) m_clamp = PosW'(1);
    if (m_clamp > MaxM) m_clamp = MaxM;
    cfg_d = make_cfg(m_clamp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= make_cfg(ResetM);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign s2_adv     = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (s2_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_mode_q <= mode_i;
      s1_word_q <= word_in_i;
    end
    if (s2_adv && s1_valid_q) begin
      out_word_q <= out_word_d;
      out_pos_q  <= out_pos_d;
      out_stat_q <= out_stat_d;
    end
  end

  hsc_datapath u_datapath (
    .mode_i           (s1_mode_q),
    .word_i           (s1_word_q),
    .cfg_i            (cfg_q),
    .word_o           (out_word_d),
    .error_position_o (out_pos_d),
    .status_o         (out_stat_d)
  );

  assign out_valid_o      = out_valid_q;
  assign word_out_o       = out_word_q;
  assign error_position_o = out_pos_q;
  assign status_o         = out_stat_q;

  `HSC_ASSERT(a_len_range,
              cfg_q.code_len >= PosW'(3) && cfg_q.code_len <= PosW'(MaxN),
              "code length out of range")
  `HSC_ASSERT(a_ok_no_pos,
              !out_valid_q || out_stat_q != STAT_OK || out_pos_q == '0,
              "clean result with nonzero syndrome")
  `HSC_ASSERT(a_corr_pos,
              !out_valid_q || out_stat_q != STAT_CORR ||
              (out_pos_q != '0 && out_pos_q <= cfg_q.code_len),
              "corrected position outside code")
  `HSC_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s2_adv,
                   s1_valid_q && $stable(s1_word_q), "stage one lost while blocked")

endmodule
